// ===== rtl/core/psr_pkg.sv =====
// psr_pkg: shared widths, status and class codes, queue entry and config types
// for the particle slot recycler; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

    // fixed field widths
    localparam int SLOT_W      = 12;
    localparam int COUNT_OUT_W = 13;
    localparam int RADIUS_W    = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int MAG_W       = 32;

    // parameter defaults
    localparam int DEF_MAX_PARTICLES = 4096;
    localparam int DEF_COORD_WIDTH   = 32;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STAR1_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAR2_RADIUS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_EXTENT = 2'd2;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_REUSED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_STAR1   = 3'd3,
        ST_STAR2   = 3'd4,
        ST_INSIDE  = 3'd5,
        ST_ESCAPED = 3'd6
    } psr_status_t;

    // outcome decided by the front end
    typedef enum logic [2:0] {
        CLS_ALLOC  = 3'd0,
        CLS_STAR1  = 3'd1,
        CLS_STAR2  = 3'd2,
        CLS_INSIDE = 3'd3,
        CLS_ESCAPE = 3'd4
    } psr_class_t;

    typedef struct packed {
        psr_class_t        cls;
        logic [SLOT_W-1:0] slot;
    } psr_entry_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] star1_radius;
        logic [RADIUS_W-1:0] star2_radius;
        logic [RADIUS_W-1:0] box_half_extent;
    } psr_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/psr_ram.sv =====
// psr_ram: generic single write port, single read port ram with registered read
// depends on psr_pkg for default sizes
`timescale 1ns / 1ps
`default_nettype none

module psr_ram #(
    parameter int WIDTH = psr_pkg::SLOT_W,
    parameter int DEPTH = psr_pkg::DEF_MAX_PARTICLES
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psr_queue.sv =====
// psr_queue: two-entry queue of classified commands between front and back end
// depends on psr_pkg
`timescale 1ns / 1ps
`default_nettype none

module psr_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire psr_pkg::psr_entry_t push_entry,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output psr_pkg::psr_entry_t      head_entry
);

    import psr_pkg::*;

    psr_entry_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign empty      = (count_reg == 2'd0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psr_front.sv =====
// psr_front: four-stage classifier; star capture tests on squared distances and
// the box test; depends on psr_pkg
`timescale 1ns / 1ps
`default_nettype none

module psr_front #(
    parameter int COORD_WIDTH = psr_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire logic                          cmd,
    input  wire logic [psr_pkg::SLOT_W-1:0]    slot,
    input  wire logic signed [COORD_WIDTH-1:0] pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] pos_z,
    input  wire logic signed [COORD_WIDTH-1:0] star1_x,
    input  wire logic signed [COORD_WIDTH-1:0] star1_y,
    input  wire logic signed [COORD_WIDTH-1:0] star1_z,
    input  wire logic signed [COORD_WIDTH-1:0] star2_x,
    input  wire logic signed [COORD_WIDTH-1:0] star2_y,
    input  wire logic signed [COORD_WIDTH-1:0] star2_z,
    input  wire psr_pkg::psr_cfg_t             cfg,
    input  wire logic                          q_full,
    output logic                               push,
    output psr_pkg::psr_entry_t                push_entry,
    output logic                               busy
);

    import psr_pkg::*;

    localparam int DW    = COORD_WIDTH + 1;
    localparam int MW    = (DW > MAG_W + 1) ? DW : MAG_W + 1;
    localparam int BW    = (COORD_WIDTH + 2 > RADIUS_W) ? COORD_WIDTH + 2 : RADIUS_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int RSQ_W = 2 * RADIUS_W;

    logic advance;

    // stage 0: captured command
    logic                          v0_reg;
    logic                          cmd0_reg;
    logic [SLOT_W-1:0]             slot0_reg;
    logic signed [COORD_WIDTH-1:0] pos_reg [3];
    logic signed [COORD_WIDTH-1:0] c1_reg [3];
    logic signed [COORD_WIDTH-1:0] c2_reg [3];

    // stage 1: magnitudes
    logic                   v1_reg;
    logic                   cmd1_reg;
    logic [SLOT_W-1:0]      slot1_reg;
    logic [MAG_W-1:0]       m1_reg [3];
    logic [MAG_W-1:0]       m2_reg [3];
    logic [2:0]             big1_reg;
    logic [2:0]             big2_reg;
    logic [COORD_WIDTH-1:0] apos_reg [3];
    logic [MAG_W-1:0]       m1_next [3];
    logic [MAG_W-1:0]       m2_next [3];
    logic [2:0]             big1_next;
    logic [2:0]             big2_next;
    logic [COORD_WIDTH-1:0] apos_next [3];

    // stage 2: squares and box flag
    logic              v2_reg;
    logic              cmd2_reg;
    logic [SLOT_W-1:0] slot2_reg;
    logic [SQ_W-1:0]   sq1_reg [3];
    logic [SQ_W-1:0]   sq2_reg [3];
    logic              sat1_2_reg;
    logic              sat2_2_reg;
    logic              box2_reg;
    logic [RSQ_W-1:0]  rsq1_2_reg;
    logic [RSQ_W-1:0]  rsq2_2_reg;
    logic              box_next;

    // stage 3: summed squares
    logic              v3_reg;
    logic              cmd3_reg;
    logic [SLOT_W-1:0] slot3_reg;
    logic [SUM_W-1:0]  sum1_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic              sat1_3_reg;
    logic              sat2_3_reg;
    logic              box3_reg;
    logic [RSQ_W-1:0]  rsq1_3_reg;
    logic [RSQ_W-1:0]  rsq2_3_reg;

    logic near1;
    logic near2;

    assign advance = !(v3_reg && q_full);
    assign busy    = v0_reg || v1_reg || v2_reg || v3_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= take;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 0 capture
    always_ff @(posedge clk)
    begin
        if (take && advance)
        begin
            cmd0_reg   <= cmd;
            slot0_reg  <= slot;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            c1_reg[0]  <= star1_x;
            c1_reg[1]  <= star1_y;
            c1_reg[2]  <= star1_z;
            c2_reg[0]  <= star2_x;
            c2_reg[1]  <= star2_y;
            c2_reg[2]  <= star2_z;
        end
    end

    // stage 1 logic: component differences, their magnitudes, and |pos|
    always_comb
    begin
        logic [DW-1:0] d1;
        logic [DW-1:0] d2;
        logic [DW-1:0] a1;
        logic [DW-1:0] a2;
        logic [MW-1:0] e1;
        logic [MW-1:0] e2;
        for (int i = 0; i < 3; i++)
        begin
            d1 = {pos_reg[i][COORD_WIDTH-1], pos_reg[i]}
                 - {c1_reg[i][COORD_WIDTH-1], c1_reg[i]};
            d2 = {pos_reg[i][COORD_WIDTH-1], pos_reg[i]}
                 - {c2_reg[i][COORD_WIDTH-1], c2_reg[i]};
            a1 = d1[DW-1] ? (~d1 + 1'b1) : d1;
            a2 = d2[DW-1] ? (~d2 + 1'b1) : d2;
            e1 = MW'(a1);
            e2 = MW'(a2);
            m1_next[i]   = e1[MAG_W-1:0];
            m2_next[i]   = e2[MAG_W-1:0];
            big1_next[i] = |e1[MW-1:MAG_W];
            big2_next[i] = |e2[MW-1:MAG_W];
            apos_next[i] = pos_reg[i][COORD_WIDTH-1] ? (~pos_reg[i] + 1'b1) : pos_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd1_reg  <= cmd0_reg;
            slot1_reg <= slot0_reg;
            big1_reg  <= big1_next;
            big2_reg  <= big2_next;
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]   <= m1_next[i];
                m2_reg[i]   <= m2_next[i];
                apos_reg[i] <= apos_next[i];
            end
        end
    end

    // stage 2 logic: box test, |x| < a, |y| < a and exact 4*|z| < a
    always_comb
    begin
        logic [BW-1:0] a_ext;
        a_ext    = BW'(cfg.box_half_extent);
        box_next = (BW'(apos_reg[0]) < a_ext) && (BW'(apos_reg[1]) < a_ext)
                   && ((BW'(apos_reg[2]) << 2) < a_ext);
    end

    // stage 2: squares of each component and of the radii
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd2_reg   <= cmd1_reg;
            slot2_reg  <= slot1_reg;
            sat1_2_reg <= |big1_reg;
            sat2_2_reg <= |big2_reg;
            box2_reg   <= box_next;
            rsq1_2_reg <= RSQ_W'(cfg.star1_radius) * RSQ_W'(cfg.star1_radius);
            rsq2_2_reg <= RSQ_W'(cfg.star2_radius) * RSQ_W'(cfg.star2_radius);
            for (int i = 0; i < 3; i++)
            begin
                sq1_reg[i] <= SQ_W'(m1_reg[i]) * SQ_W'(m1_reg[i]);
                sq2_reg[i] <= SQ_W'(m2_reg[i]) * SQ_W'(m2_reg[i]);
            end
        end
    end

    // stage 3: sums kept wide enough that they cannot overflow
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd3_reg   <= cmd2_reg;
            slot3_reg  <= slot2_reg;
            sat1_3_reg <= sat1_2_reg;
            sat2_3_reg <= sat2_2_reg;
            box3_reg   <= box2_reg;
            rsq1_3_reg <= rsq1_2_reg;
            rsq2_3_reg <= rsq2_2_reg;
            sum1_reg   <= SUM_W'(sq1_reg[0]) + SUM_W'(sq1_reg[1]) + SUM_W'(sq1_reg[2]);
            sum2_reg   <= SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
        end
    end

    // classify and hand to the queue; primary star first, then secondary, then box
    assign near1 = !sat1_3_reg && (sum1_reg < SUM_W'(rsq1_3_reg));
    assign near2 = !sat2_3_reg && (sum2_reg < SUM_W'(rsq2_3_reg));

    always_comb
    begin
        push            = v3_reg && !q_full;
        push_entry.slot = slot3_reg;
        if (cmd3_reg == CMD_ALLOC)
        begin
            push_entry.cls = CLS_ALLOC;
        end
        else if (near1)
        begin
            push_entry.cls = CLS_STAR1;
        end
        else if (near2)
        begin
            push_entry.cls = CLS_STAR2;
        end
        else if (box3_reg)
        begin
            push_entry.cls = CLS_INSIDE;
        end
        else
        begin
            push_entry.cls = CLS_ESCAPE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psr_back.sv =====
// psr_back: free index fifo (ram, head, tail, count) and fresh counter; carries
// out classified commands and drives the result; depends on psr_pkg, psr_ram
`timescale 1ns / 1ps
`default_nettype none

module psr_back #(
    parameter int MAX_PARTICLES = psr_pkg::DEF_MAX_PARTICLES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    input  wire psr_pkg::psr_entry_t             q_entry,
    output logic                                 q_pop,
    output logic                                 busy,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic [psr_pkg::SLOT_W-1:0]           result_slot,
    output logic [psr_pkg::COUNT_OUT_W-1:0]      slots_used,
    output logic [psr_pkg::COUNT_OUT_W-1:0]      free_entries
);

    import psr_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_READ = 2'b10
    } psr_back_state_t;

    psr_back_state_t state_reg;
    psr_back_state_t state_next;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] free_count_reg;
    logic [CW-1:0] free_count_next;
    logic [CW-1:0] fresh_count_reg;
    logic [CW-1:0] fresh_count_next;

    logic                   done_reg;
    logic                   done_next;
    psr_status_t            status_reg;
    psr_status_t            status_next;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic [COUNT_OUT_W-1:0] used_reg;
    logic [COUNT_OUT_W-1:0] free_reg;

    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] rd_data;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        wrap_inc = (idx == AW'(MAX_PARTICLES - 1)) ? '0 : idx + AW'(1);
    endfunction

    psr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_PARTICLES)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (q_entry.slot),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // command execution
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        free_count_next  = free_count_reg;
        fresh_count_next = fresh_count_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        slot_next        = slot_reg;
        q_pop            = 1'b0;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_entry.cls == CLS_ALLOC)
                    begin
                        if (free_count_reg != '0)
                        begin
                            // reuse the oldest freed index, data back next cycle
                            rd_en           = 1'b1;
                            head_next       = wrap_inc(head_reg);
                            free_count_next = free_count_reg - CW'(1);
                            state_next      = B_READ;
                        end
                        else if (fresh_count_reg < CW'(MAX_PARTICLES))
                        begin
                            done_next        = 1'b1;
                            status_next      = ST_NEW;
                            slot_next        = SLOT_W'(fresh_count_reg);
                            fresh_count_next = fresh_count_reg + CW'(1);
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            slot_next   = '0;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        slot_next = q_entry.slot;
                        case (q_entry.cls)
                            CLS_STAR1:  status_next = ST_STAR1;
                            CLS_STAR2:  status_next = ST_STAR2;
                            CLS_INSIDE: status_next = ST_INSIDE;
                            default:    status_next = ST_ESCAPED;
                        endcase
                        // retired slot goes to the free fifo unless it is full
                        if (q_entry.cls != CLS_INSIDE && free_count_reg < CW'(MAX_PARTICLES))
                        begin
                            wr_en           = 1'b1;
                            tail_next       = wrap_inc(tail_reg);
                            free_count_next = free_count_reg + CW'(1);
                        end
                    end
                end
            end
            B_READ:
            begin
                done_next   = 1'b1;
                status_next = ST_REUSED;
                slot_next   = rd_data;
                state_next  = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            free_count_reg  <= '0;
            fresh_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            free_count_reg  <= free_count_next;
            fresh_count_reg <= fresh_count_next;
            done_reg        <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
        used_reg   <= COUNT_OUT_W'(fresh_count_next);
        free_reg   <= COUNT_OUT_W'(free_count_next);
    end

    assign busy         = (state_reg == B_READ);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_slot  = slot_reg;
    assign slots_used   = used_reg;
    assign free_entries = free_reg;

endmodule

`default_nettype wire

// ===== rtl/core/particle_slot_recycler.sv =====
// particle_slot_recycler: slot allocator and retirement tester; one command at a time.
// the result strobe follows the four classifier stages, the queue and the result
// register, plus the registered free-list ram read for a reused slot. a new command
// is taken only after the previous one has left the classifier, queue and ram read.
// reset: counters, pointers and config cleared; free-list ram contents undefined.
// results are strobed on done for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module particle_slot_recycler #(
    parameter int MAX_PARTICLES = psr_pkg::DEF_MAX_PARTICLES,
    parameter int COORD_WIDTH   = psr_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cmd,
    input  wire logic [psr_pkg::SLOT_W-1:0]        slot,
    input  wire logic signed [COORD_WIDTH-1:0]     pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]     pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]     pos_z,
    input  wire logic signed [COORD_WIDTH-1:0]     star1_x,
    input  wire logic signed [COORD_WIDTH-1:0]     star1_y,
    input  wire logic signed [COORD_WIDTH-1:0]     star1_z,
    input  wire logic signed [COORD_WIDTH-1:0]     star2_x,
    input  wire logic signed [COORD_WIDTH-1:0]     star2_y,
    input  wire logic signed [COORD_WIDTH-1:0]     star2_z,
    input  wire logic                              cfg_we,
    input  wire logic [psr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [psr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   done,
    output logic [2:0]                             status,
    output logic [psr_pkg::SLOT_W-1:0]             result_slot,
    output logic [psr_pkg::COUNT_OUT_W-1:0]        slots_used,
    output logic [psr_pkg::COUNT_OUT_W-1:0]        free_entries
);

    import psr_pkg::*;

    psr_cfg_t   cfg_reg;
    psr_cfg_t   cfg_next;
    psr_entry_t push_entry;
    psr_entry_t head_entry;
    logic       take;
    logic       push;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       front_busy;
    logic       back_busy;

    // busy while any command is in the classifier, the queue or the free-list read
    assign busy = front_busy || !q_empty || back_busy;
    assign take = start && !busy;

    // config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STAR1_RADIUS:    cfg_next.star1_radius    = cfg_data;
                CFG_STAR2_RADIUS:    cfg_next.star2_radius    = cfg_data;
                CFG_BOX_HALF_EXTENT: cfg_next.box_half_extent = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .cmd        (cmd),
        .slot       (slot),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .star1_x    (star1_x),
        .star1_y    (star1_y),
        .star1_z    (star1_z),
        .star2_x    (star2_x),
        .star2_y    (star2_y),
        .star2_z    (star2_z),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .busy       (front_busy)
    );

    psr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_entry (head_entry)
    );

    psr_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_entry      (head_entry),
        .q_pop        (q_pop),
        .busy         (back_busy),
        .done         (done),
        .status       (status),
        .result_slot  (result_slot),
        .slots_used   (slots_used),
        .free_entries (free_entries)
    );

endmodule

`default_nettype wire
